// File: rtl/task_timing_stats_table_macros.svh
// Assertion macros for the task timing statistics table.
// Used by the top level only; no other dependencies.
`ifndef TASK_TIMING_STATS_TABLE_MACROS_SVH
`define TASK_TIMING_STATS_TABLE_MACROS_SVH
// a implies b on the same edge
`define TTS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b on the next edge
`define TTS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: rtl/tts_pkg.sv
// Shared types and constants for the task timing statistics table.
// No dependencies.
package tts_pkg;
  localparam int unsigned TW = 48;
  localparam int unsigned PW = 22;
  localparam int unsigned UW = 15;
  localparam logic [UW-1:0] FULL_UTIL = 15'd25600;
  localparam logic [TW-1:0] M48 = {TW{1'b1}};

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0, CMD_START = 3'd1, CMD_END = 3'd2,
    CMD_WAKE = 3'd3, CMD_BLOCK = 3'd4, CMD_PERIOD = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNKNOWN = 3'd1, ST_FULL = 3'd2,
    ST_RUNNING = 3'd3, ST_IDLE = 3'd4
  } status_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

// File: rtl/tts_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// File: rtl/tts_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit quotient.
// Depends on tts_pkg.
module tts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tts_pkg::div_req_t req,
  output tts_pkg::div_rsp_t rsp
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic [48:0] trial;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r;
    trial = '0;
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 7'd64; q_nxt = req.num;
      rem_nxt = '0; den_nxt = req.den;
    end else if (busy_r) begin
      trial = {rem_r[47:0], q_r[63]};
      q_nxt = {q_r[62:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule

// File: rtl/task_timing_stats_table.sv
// Task timing statistics table, top level; uses tts_pkg, tts_ram, tts_div, macros header.
// Event commands: the id search reads every slot (read, then compare), then the hit entry
// gets a read-modify-write; in_ready stays low until the result has been taken.
// Period end: empty slots are skipped; each live slot gets a utilization division (skipped
// if the period length is zero), an averaging division and a report; in_ready low until done.
// Reset (rst_n, sync) clears valid bits and control; table RAM is not cleared.
`include "task_timing_stats_table_macros.svh"
module task_timing_stats_table #(
  parameter int unsigned TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [21:0] in_task_pid,
  input  logic [47:0] in_time_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [47:0] out_duration,
  output logic [21:0] out_report_pid,
  output logic [14:0] out_util,
  output logic [14:0] out_util_min,
  output logic [14:0] out_util_avg,
  output logic        out_last
);
  localparam int unsigned AW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CW = $clog2(TASKS + 1);
  // entry record: pid, running, start, wake, blocked, pexec, esw, usum, uper, ulow
  localparam int unsigned RW = 22 + 1 + 48 + 48 + 1 + 48 + 48 + 32 + 16 + 15;

  typedef struct packed {
    logic [21:0] pid;
    logic        running;
    logic [47:0] start;
    logic [47:0] wake;
    logic        blocked;
    logic [47:0] pexec;
    logic [47:0] esw;
    logic [31:0] usum;
    logic [15:0] uper;
    logic [14:0] ulow;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SWAIT, S_EXEC, S_PRD, S_PWAIT, S_PDIV, S_PMUL,
    S_PUPD, S_AVG, S_PEMIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [TASKS-1:0] valid_r, valid_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [21:0] pid_r, pid_nxt;
  logic [47:0] t_r, t_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic hfound_r, hfound_nxt, ffound_r, ffound_nxt;
  logic pany_r, pany_nxt, pend_r, pend_nxt;
  rec_t rec_r, rec_nxt;
  logic [14:0] u_r, u_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [47:0] odur_r, odur_nxt;
  logic [21:0] opid_r, opid_nxt;
  logic [14:0] ou_r, ou_nxt, omin_r, omin_nxt, oavg_r, oavg_nxt;
  logic        olast_r, olast_nxt;
  logic [AW-1:0] pnext_r, pnext_nxt;
  logic          pmore_r, pmore_nxt;
  logic [63:0] prod_r, prod_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  rec_t wrec, rrec;
  logic [RW-1:0] rdata;
  tts_pkg::div_req_t dreq;
  tts_pkg::div_rsp_t drsp;

  tts_ram #(.WIDTH(RW), .DEPTH(TASKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rdata)
  );
  assign rrec = rdata;

  tts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? tts_pkg::M48 : s[47:0];
  endfunction

  logic [AW-1:0] idx_a;
  logic [47:0] run;
  logic [47:0] quo_c;
  assign idx_a = idx_r[AW-1:0];
  assign quo_c = (drsp.quo[63:15] != '0) ? 48'(tts_pkg::FULL_UTIL) : 48'(drsp.quo[14:0]);

  always_comb begin
    state_nxt = state_r; valid_nxt = valid_r; cmd_nxt = cmd_r; pid_nxt = pid_r;
    t_nxt = t_r; idx_nxt = idx_r; hit_nxt = hit_r; free_nxt = free_r;
    hfound_nxt = hfound_r; ffound_nxt = ffound_r; pany_nxt = pany_r;
    pend_nxt = pend_r; rec_nxt = rec_r; u_nxt = u_r;
    ov_nxt = ov_r; ost_nxt = ost_r; odur_nxt = odur_r; opid_nxt = opid_r;
    ou_nxt = ou_r; omin_nxt = omin_r; oavg_nxt = oavg_r; olast_nxt = olast_r;
    pnext_nxt = pnext_r; pmore_nxt = pmore_r; prod_nxt = prod_r;
    we = 1'b0; waddr = idx_a; wrec = rec_r; raddr = idx_a;
    dreq = '0; run = (t_r - rec_r.start);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd; pid_nxt = in_task_pid; t_nxt = in_time_req;
          idx_nxt = '0; hfound_nxt = 1'b0; ffound_nxt = 1'b0; pany_nxt = 1'b0;
          ost_nxt = tts_pkg::ST_OK; odur_nxt = '0; opid_nxt = '0;
          ou_nxt = '0; omin_nxt = '0; oavg_nxt = '0; olast_nxt = 1'b1;
          if (in_cmd == tts_pkg::CMD_PERIOD) begin
            state_nxt = S_PRD;
          end else if (in_cmd > tts_pkg::CMD_PERIOD) begin
            ov_nxt = 1'b1; state_nxt = S_OUT;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // read entry idx; compare next cycle
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (valid_r[idx_a] && rrec.pid == pid_r && !hfound_r) begin
          hfound_nxt = 1'b1; hit_nxt = idx_a;
        end
        if (!valid_r[idx_a] && !ffound_r) begin
          ffound_nxt = 1'b1; free_nxt = idx_a;
        end
        if (idx_r == CW'(TASKS - 1)) begin
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_SEARCH;
        end
      end
      S_EXEC: begin
        // raddr held at hit for this read cycle: use pipelined read below
        raddr = hit_r;
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          rec_nxt = rrec;
          ov_nxt = 1'b1; state_nxt = S_OUT;
          waddr = hit_r; wrec = rrec;
          run = t_r - rrec.start;
          unique case (cmd_r)
            tts_pkg::CMD_CREATE: begin
              if (!hfound_r) begin
                if (!ffound_r) begin
                  ost_nxt = tts_pkg::ST_FULL;
                end else begin
                  we = 1'b1; waddr = free_r;
                  valid_nxt[free_r] = 1'b1;
                  wrec = '0; wrec.pid = pid_r; wrec.wake = t_r;
                  wrec.ulow = tts_pkg::FULL_UTIL;
                end
              end
            end
            default: begin
              if (!hfound_r) begin
                ost_nxt = tts_pkg::ST_UNKNOWN;
              end else if (cmd_r == tts_pkg::CMD_START) begin
                if (rrec.running) begin
                  ost_nxt = tts_pkg::ST_RUNNING;
                end else begin
                  we = 1'b1; wrec.start = t_r; wrec.running = 1'b1;
                end
              end else if (cmd_r == tts_pkg::CMD_END) begin
                if (!rrec.running) begin
                  ost_nxt = tts_pkg::ST_IDLE;
                end else begin
                  we = 1'b1; wrec.running = 1'b0;
                  wrec.pexec = sat_add(rrec.pexec, run);
                  wrec.esw = sat_add(rrec.esw, run);
                  if (rrec.blocked) odur_nxt = sat_add(rrec.esw, run);
                end
              end else if (cmd_r == tts_pkg::CMD_WAKE) begin
                if (rrec.blocked) begin
                  we = 1'b1; odur_nxt = t_r - rrec.wake;
                  wrec.wake = t_r; wrec.esw = '0; wrec.blocked = 1'b0;
                end
              end else begin
                we = 1'b1; wrec.blocked = 1'b1; odur_nxt = t_r - rrec.wake;
              end
            end
          endcase
        end
      end
      S_PRD: begin
        if (idx_r == CW'(TASKS)) begin
          if (pany_r) begin
            olast_nxt = 1'b1; ov_nxt = 1'b1;
          end
          state_nxt = pany_r ? S_OUT : S_IDLE;
        end else if (!valid_r[idx_a]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        rec_nxt = rrec;
        // pexec * 25600 as shifted adds
        prod_nxt = (64'(rrec.pexec) << 14) + (64'(rrec.pexec) << 13) +
                   (64'(rrec.pexec) << 10);
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        if (t_r == '0) begin
          u_nxt = (rec_r.pexec != '0) ? tts_pkg::FULL_UTIL : '0;
          state_nxt = S_PUPD;
        end else begin
          dreq.start = 1'b1; dreq.num = prod_r; dreq.den = t_r;
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (drsp.done) begin
          u_nxt = (quo_c > 48'(tts_pkg::FULL_UTIL)) ? tts_pkg::FULL_UTIL : quo_c[14:0];
          state_nxt = S_PUPD;
        end
      end
      S_PUPD: begin
        if (rec_r.uper != 16'hFFFF) begin
          rec_nxt.uper = rec_r.uper + 16'd1;
          rec_nxt.usum = rec_r.usum + 32'(u_r);
        end
        if (u_r < rec_r.ulow) rec_nxt.ulow = u_r;
        rec_nxt.pexec = '0;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        we = 1'b1; wrec = rec_r;
        dreq.start = 1'b1; dreq.num = 64'(rec_r.usum); dreq.den = 48'(rec_r.uper);
        state_nxt = S_PEMIT;
      end
      S_PEMIT: begin
        if (drsp.done) begin
          // a report from an earlier live entry is pending: send it, marked not last
          if (pany_r) begin
            olast_nxt = 1'b0; ov_nxt = 1'b1; state_nxt = S_OUT;
          end
          pany_nxt = 1'b1;
          // stage this report; previous one (if any) goes out first
          pnext_nxt = idx_a;
          pmore_nxt = 1'b1;
          if (!pany_r) begin
            opid_nxt = rec_r.pid; ou_nxt = u_r; omin_nxt = rec_r.ulow;
            oavg_nxt = drsp.quo[14:0];
            idx_nxt = idx_r + 1'b1; state_nxt = S_PRD; pmore_nxt = 1'b0;
          end else begin
            prod_nxt = {drsp.quo[14:0], 49'(0)};
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (pmore_r) begin
            pmore_nxt = 1'b0;
            opid_nxt = rec_r.pid; ou_nxt = u_r; omin_nxt = rec_r.ulow;
            oavg_nxt = prod_r[63:49]; olast_nxt = 1'b1;
            idx_nxt = CW'(pnext_r) + 1'b1; state_nxt = S_PRD;
          end else if (cmd_r == tts_pkg::CMD_PERIOD && idx_r != CW'(TASKS)) begin
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_PRD && idx_r != CW'(TASKS)) raddr = idx_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; ov_r <= 1'b0; pend_r <= 1'b0;
      pmore_r <= 1'b0; pany_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; ov_r <= ov_nxt; pend_r <= pend_nxt;
      pmore_r <= pmore_nxt; pany_r <= pany_nxt;
    end
    cmd_r <= cmd_nxt; pid_r <= pid_nxt; t_r <= t_nxt; idx_r <= idx_nxt;
    hit_r <= hit_nxt; free_r <= free_nxt; hfound_r <= hfound_nxt; ffound_r <= ffound_nxt;
    rec_r <= rec_nxt; u_r <= u_nxt; ost_r <= ost_nxt; odur_r <= odur_nxt;
    opid_r <= opid_nxt; ou_r <= ou_nxt; omin_r <= omin_nxt; oavg_r <= oavg_nxt;
    olast_r <= olast_nxt; pnext_r <= pnext_nxt; prod_r <= prod_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_duration   = odur_r;
  assign out_report_pid = opid_r;
  assign out_util       = ou_r;
  assign out_util_min   = omin_r;
  assign out_util_avg   = oavg_r;
  assign out_last       = olast_r;

  `TTS_ASSERT_IMP(a_ready_out, in_ready, !out_valid)
  `TTS_ASSERT_IMP(a_out_state, out_valid, state_r == S_OUT)
  `TTS_ASSERT_NXT(a_div_busy, dreq.start, drsp.busy)
endmodule

// File: dv/tb_top.sv
// Testbench for task_timing_stats_table: random and directed trace events,
// results checked against a behavioral table model. Depends on tts_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic [47:0] MAXT = 48'hFFFF_FFFF_FFFF;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] duration;
    logic [21:0] report_pid;
    logic [14:0] util;
    logic [14:0] util_min;
    logic [14:0] util_avg;
    logic        last;
  } event_rpt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] in_cmd = '0;
  logic [21:0] in_task_pid = '0;
  logic [47:0] in_time_req = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] out_status;
  logic [47:0] out_duration;
  logic [21:0] out_report_pid;
  logic [14:0] out_util, out_util_min, out_util_avg;
  logic out_last;

  task_timing_stats_table #(.TASKS(NSLOT)) u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic        tbl_valid[NSLOT];
  logic [21:0] tbl_pid[NSLOT];
  logic        tbl_run[NSLOT];
  logic [47:0] tbl_start[NSLOT];
  logic [47:0] tbl_wake[NSLOT];
  logic        tbl_blocked[NSLOT];
  logic [47:0] tbl_pexec[NSLOT];
  logic [47:0] tbl_wexec[NSLOT];
  logic [31:0] tbl_usum[NSLOT];
  logic [15:0] tbl_nper[NSLOT];
  logic [14:0] tbl_ulow[NSLOT];

  event_rpt_t expected_rpts[$];
  int err_count = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  logic [21:0] live_pids[$];

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAXT : s[47:0];
  endfunction

  function automatic void predict_event(logic [2:0] cmd, logic [21:0] pid, logic [47:0] t);
    event_rpt_t r;
    int idx, f, lastk;
    logic [47:0] run;
    logic [63:0] u;
    idx = -1;
    r = '0;
    r.last = 1'b1;
    if (cmd == tts_pkg::CMD_PERIOD) begin
      lastk = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!tbl_valid[i]) continue;
        if (t == '0) u = (tbl_pexec[i] != '0) ? 64'(tts_pkg::FULL_UTIL) : 64'd0;
        else u = ({16'd0, tbl_pexec[i]} * 64'd25600) / {16'd0, t};
        if (u > 64'(tts_pkg::FULL_UTIL)) u = 64'(tts_pkg::FULL_UTIL);
        if (tbl_nper[i] != 16'hFFFF) begin
          tbl_nper[i]++;
          tbl_usum[i] += u[31:0];
        end
        if (u[14:0] < tbl_ulow[i]) tbl_ulow[i] = u[14:0];
        tbl_pexec[i] = '0;
        r = '0;
        r.report_pid = tbl_pid[i];
        r.util = u[14:0];
        r.util_min = tbl_ulow[i];
        r.util_avg = 15'(tbl_usum[i] / tbl_nper[i]);
        expected_rpts.push_back(r);
        lastk = expected_rpts.size() - 1;
      end
      if (lastk >= 0) expected_rpts[lastk].last = 1'b1;
      return;
    end
    if (cmd > tts_pkg::CMD_PERIOD) begin
      expected_rpts.push_back(r);
      return;
    end
    for (int i = 0; i < NSLOT; i++)
      if (idx < 0 && tbl_valid[i] && tbl_pid[i] == pid) idx = i;
    if (cmd == tts_pkg::CMD_CREATE) begin
      if (idx < 0) begin
        f = 0;
        while (f < NSLOT && tbl_valid[f]) f++;
        if (f >= NSLOT) r.status = tts_pkg::ST_FULL;
        else begin
          tbl_valid[f] = 1'b1; tbl_pid[f] = pid; tbl_run[f] = 1'b0;
          tbl_start[f] = '0; tbl_wake[f] = t; tbl_blocked[f] = 1'b0;
          tbl_pexec[f] = '0; tbl_wexec[f] = '0; tbl_usum[f] = '0;
          tbl_nper[f] = '0; tbl_ulow[f] = tts_pkg::FULL_UTIL;
        end
      end
    end else if (idx < 0) r.status = tts_pkg::ST_UNKNOWN;
    else if (cmd == tts_pkg::CMD_START) begin
      if (tbl_run[idx]) r.status = tts_pkg::ST_RUNNING;
      else begin
        tbl_start[idx] = t; tbl_run[idx] = 1'b1;
      end
    end else if (cmd == tts_pkg::CMD_END) begin
      if (!tbl_run[idx]) r.status = tts_pkg::ST_IDLE;
      else begin
        run = t - tbl_start[idx];
        tbl_run[idx] = 1'b0;
        tbl_pexec[idx] = sat_add(tbl_pexec[idx], run);
        tbl_wexec[idx] = sat_add(tbl_wexec[idx], run);
        if (tbl_blocked[idx]) r.duration = tbl_wexec[idx];
      end
    end else if (cmd == tts_pkg::CMD_WAKE) begin
      if (tbl_blocked[idx]) begin
        r.duration = t - tbl_wake[idx];
        tbl_wake[idx] = t; tbl_wexec[idx] = '0; tbl_blocked[idx] = 1'b0;
      end
    end else begin
      tbl_blocked[idx] = 1'b1;
      r.duration = t - tbl_wake[idx];
    end
    expected_rpts.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_event(logic [2:0] cmd, logic [21:0] pid, logic [47:0] t);
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_task_pid <= pid;
    in_time_req <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(cmd, pid, t);
  endtask

  // receiver
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        while (hold_off > 0) begin
          @(posedge clk);
          hold_off--;
        end
      end
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    event_rpt_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rpts.size() == 0) report_mismatch("unexpected transfer", 64'd0, 64'd0);
      else begin
        w = expected_rpts.pop_front();
        if (out_status != w.status)
          report_mismatch("status", 64'(out_status), 64'(w.status));
        if (out_duration != w.duration)
          report_mismatch("duration", 64'(out_duration), 64'(w.duration));
        if (out_report_pid != w.report_pid)
          report_mismatch("report_pid", 64'(out_report_pid), 64'(w.report_pid));
        if (out_util != w.util) report_mismatch("util", 64'(out_util), 64'(w.util));
        if (out_util_min != w.util_min)
          report_mismatch("util_min", 64'(out_util_min), 64'(w.util_min));
        if (out_util_avg != w.util_avg)
          report_mismatch("util_avg", 64'(out_util_avg), 64'(w.util_avg));
        if (out_last != w.last) report_mismatch("last", 64'(out_last), 64'(w.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [47:0] rand_time();
    case ($urandom_range(0, 3))
      0: return 48'($urandom_range(0, 1000));
      1: return MAXT - 48'($urandom_range(0, 1000));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [21:0] pick_pid();
    if (live_pids.size() > 0 && $urandom_range(0, 9) != 0)
      return live_pids[$urandom_range(0, live_pids.size() - 1)];
    return 22'($urandom);
  endfunction

  task automatic test_directed();
    logic [21:0] p0;
    p0 = 22'h3FFFFF;
    send_event(tts_pkg::CMD_PERIOD, 22'd0, 48'd100);   // empty table
    send_event(tts_pkg::CMD_START, p0, 48'd0);         // unknown
    send_event(tts_pkg::CMD_CREATE, p0, 48'd10);
    send_event(tts_pkg::CMD_CREATE, p0, 48'd20);       // existing id
    send_event(tts_pkg::CMD_END, p0, 48'd5);           // not running
    send_event(tts_pkg::CMD_WAKE, p0, 48'd30);         // not blocked
    send_event(tts_pkg::CMD_START, p0, MAXT - 48'd5);
    send_event(tts_pkg::CMD_START, p0, 48'd1);         // already running
    send_event(tts_pkg::CMD_END, p0, 48'd20);          // wraps
    send_event(tts_pkg::CMD_BLOCK, p0, 48'd5);
    send_event(tts_pkg::CMD_START, p0, 48'd0);
    send_event(tts_pkg::CMD_END, p0, MAXT);            // saturates
    send_event(tts_pkg::CMD_WAKE, p0, 48'd100);
    send_event(tts_pkg::CMD_PERIOD, 22'd0, 48'd0);     // zero length
    send_event(tts_pkg::CMD_PERIOD, 22'h3FFFFF, MAXT);
    send_event(CMD_SPARE_LO, p0, 48'd1);
    send_event(CMD_SPARE_HI, 22'h3FFFFF, MAXT);
    for (int i = 0; i < 16; i++) send_event(tts_pkg::CMD_CREATE, 22'(i), 48'(i));
    live_pids.push_back(p0);
    for (int i = 0; i < 15; i++) live_pids.push_back(22'(i));
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_event(tts_pkg::CMD_WAKE, live_pids[i], 48'(i));
  endtask

  task automatic test_random();
    logic [21:0] p;
    logic [47:0] t;
    t = 48'd0;
    for (int n = 0; n < 440; n++) begin
      p = pick_pid();
      t = ($urandom_range(0, 19) == 0) ? rand_time() : t + 48'($urandom_range(0, 5000));
      case ($urandom_range(0, 19))
        0: send_event(tts_pkg::CMD_CREATE, p, t);
        1: send_event(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 22'($urandom),
                      rand_time());
        2: send_event(tts_pkg::CMD_PERIOD, 22'($urandom),
                      ($urandom_range(0, 3) == 0) ? rand_time() : 48'($urandom_range(0, 60000)));
        3, 4: send_event(tts_pkg::CMD_BLOCK, p, t);
        5, 6, 7: send_event(tts_pkg::CMD_WAKE, p, t);
        8, 9, 10, 11, 12: send_event(tts_pkg::CMD_START, p, t);
        default: send_event(tts_pkg::CMD_END, p, t);
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (expected_rpts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
